@@ design/dsrc_pkg.sv @@
// dsrc_pkg: shared types and constants of the dark spot region counter
// no dependencies; used by every module of the block by scoped names

package dsrc_pkg;

    localparam int unsigned CNT_W       = 22;
    localparam logic [CNT_W-1:0] CNT_MAX = 22'h3F_FFFF;
    localparam int unsigned MAX_HEIGHT  = 2048;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_DARK_THRESHOLD = 2'd2;

    localparam logic [11:0] RST_IMAGE_WIDTH    = 12'd640;
    localparam logic [11:0] RST_IMAGE_HEIGHT   = 12'd480;
    localparam logic [7:0]  RST_DARK_THRESHOLD = 8'd60;

    // queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    typedef struct packed {
        logic [7:0] gray_level;
        logic [7:0] region_label;
    } t_in_item;

    typedef struct packed {
        logic [10:0]      pixel_row;
        logic [10:0]      pixel_col;
        logic             dark_mark;
        logic [7:0]       region_id;
        logic [CNT_W-1:0] region_pixel_count;
        logic [CNT_W-1:0] region_dark_count;
    } t_out_item;

    // classified pixel handed from front to back
    typedef struct packed {
        logic [10:0] pixel_row;
        logic [10:0] pixel_col;
        logic        dark_mark;
        logic [7:0]  region_id;
    } t_queue_item;

    typedef struct packed {
        logic [11:0] image_width;
        logic [11:0] image_height;
        logic [7:0]  dark_threshold;
    } t_cfg;

endpackage

@@ design/dsrc_front.sv @@
// dsrc_front: raster position, line stores, window and dark classification
// depends on dsrc_pkg

module dsrc_front #(
    parameter int unsigned WINDOW      = 3,
    parameter int unsigned MAX_WIDTH   = 2048,
    parameter int unsigned NUM_REGIONS = 256,
    parameter int unsigned CLR_W       = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_in_valid,
    input  dsrc_pkg::t_in_item    i_in_data,
    input  dsrc_pkg::t_cfg        i_cfg,
    input  logic                  i_clr_active,
    input  logic [CLR_W-1:0]      i_clr_idx,
    output logic                  o_push,
    output dsrc_pkg::t_queue_item o_push_data
);

    localparam int unsigned LINES = WINDOW - 1;
    localparam int unsigned CW    = $clog2(MAX_WIDTH);
    localparam int unsigned RSW   = $clog2(WINDOW * 255 + 1);
    localparam int unsigned RCW   = $clog2(WINDOW + 1);
    localparam int unsigned SUMW  = $clog2(WINDOW * WINDOW * 255 + 1);
    localparam int unsigned CNTW  = $clog2(WINDOW * WINDOW + 1);
    localparam int unsigned EDGE0 = 2 * WINDOW - 1;

    typedef struct packed {
        logic [LINES-1:0][7:0] lab;
        logic [LINES-1:0][7:0] gray;
    } t_line;

    t_line mem [MAX_WIDTH];

    logic [CW-1:0]  r_col;
    logic [10:0]    r_row;
    logic [12:0]    effw;
    logic [11:0]    effh;
    logic [12:0]    col_inc;
    logic [11:0]    row_inc;
    logic           eval_pos;
    logic           accept;

    t_line          r_rd_q;
    logic           r_fwd;
    t_line          r_fwd_line;
    t_line          line_cur;
    t_line          n_line;
    logic           line_we;

    logic           r_s1_valid;
    logic           r_s1_eval;
    logic [7:0]     r_s1_g;
    logic [7:0]     r_s1_lab;
    logic [CW-1:0]  r_s1_c;
    logic [10:0]    r_s1_r;

    logic [WINDOW-1:0][WINDOW-1:0][7:0] r_gwin;
    logic [WINDOW-1:0][7:0]             r_ldelay;
    logic [WINDOW-1:0][7:0]             col_g;

    logic           lbl_ok;
    logic           r_s2_valid;
    logic [10:0]    r_s2_r;
    logic [10:0]    r_s2_c;
    logic [7:0]     r_s2_lbl;

    logic [WINDOW-1:0][RSW-1:0] row_sum;
    logic [WINDOW-1:0][RCW-1:0] row_cnt;
    logic                       r_s3_valid;
    logic [10:0]                r_s3_r;
    logic [10:0]                r_s3_c;
    logic [7:0]                 r_s3_lbl;
    logic [WINDOW-1:0][RSW-1:0] r_s3_sum;
    logic [WINDOW-1:0][RCW-1:0] r_s3_cnt;

    logic [SUMW-1:0] tot_sum;
    logic [CNTW-1:0] tot_cnt;
    logic            r_s4_valid;
    logic [10:0]     r_s4_r;
    logic [10:0]     r_s4_c;
    logic [7:0]      r_s4_lbl;
    logic [SUMW-1:0] r_s4_sum;
    logic [CNTW-1:0] r_s4_cnt;
    logic [8+CNTW-1:0] thr_prod;

    assign accept = i_en && i_in_valid;

    // effective frame size and position stepping
    always_comb begin
        effw = (13'(i_cfg.image_width) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH)
                                                          : 13'(i_cfg.image_width);
        effh = (i_cfg.image_height > 12'(dsrc_pkg::MAX_HEIGHT))
             ? 12'(dsrc_pkg::MAX_HEIGHT) : i_cfg.image_height;
        col_inc  = 13'(r_col) + 13'd1;
        row_inc  = 12'(r_row) + 12'd1;
        eval_pos = (r_row >= 11'(EDGE0)) && (13'(r_col) >= 13'(EDGE0))
                && (13'(r_col) + 13'd2 <= effw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (col_inc >= effw) begin
                r_col <= '0;
                r_row <= (row_inc >= effh) ? 11'd0 : row_inc[10:0];
            end else begin
                r_col <= col_inc[CW-1:0];
            end
        end
    end

    // line store: one entry per column holds all stored rows
    assign line_we = i_en && r_s1_valid;

    always_ff @(posedge i_clk) begin
        if (i_clr_active) begin
            if (32'(i_clr_idx) < MAX_WIDTH) begin
                mem[i_clr_idx[CW-1:0]] <= '0;
            end
        end else if (line_we) begin
            mem[r_s1_c] <= n_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd_q     <= mem[r_col];
            r_fwd      <= line_we && (r_s1_c == r_col);
            r_fwd_line <= n_line;
        end
    end

    always_comb begin
        line_cur = r_fwd ? r_fwd_line : r_rd_q;
        for (int k = 0; k < LINES - 1; k++) begin
            n_line.gray[k] = line_cur.gray[k+1];
            n_line.lab[k]  = line_cur.lab[k+1];
        end
        n_line.gray[LINES-1] = r_s1_g;
        n_line.lab[LINES-1]  = r_s1_lab;
        for (int k = 0; k < LINES; k++) begin
            col_g[k] = line_cur.gray[k];
        end
        col_g[WINDOW-1] = r_s1_g;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_eval <= eval_pos;
            r_s1_g    <= i_in_data.gray_level;
            r_s1_lab  <= i_in_data.region_label;
            r_s1_c    <= r_col;
            r_s1_r    <= r_row;
        end
    end

    // window registers and label delay
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gwin   <= '0;
            r_ldelay <= '0;
        end else if (line_we) begin
            for (int k = 0; k < WINDOW; k++) begin
                for (int m = 0; m < WINDOW - 1; m++) begin
                    r_gwin[k][m] <= r_gwin[k][m+1];
                end
                r_gwin[k][WINDOW-1] <= col_g[k];
            end
            for (int m = 0; m < WINDOW - 1; m++) begin
                r_ldelay[m] <= r_ldelay[m+1];
            end
            r_ldelay[WINDOW-1] <= line_cur.lab[0];
        end
    end

    // label of the evaluated pixel, after this shift
    assign lbl_ok = (r_ldelay[1] != 8'd0) && (9'(r_ldelay[1]) < 9'(NUM_REGIONS));

    always_comb begin
        for (int k = 0; k < WINDOW; k++) begin
            row_sum[k] = '0;
            row_cnt[k] = '0;
            for (int m = 0; m < WINDOW; m++) begin
                row_sum[k] = row_sum[k] + RSW'(r_gwin[k][m]);
                row_cnt[k] = row_cnt[k] + RCW'(r_gwin[k][m] != 8'd0);
            end
        end
        tot_sum = '0;
        tot_cnt = '0;
        for (int k = 0; k < WINDOW; k++) begin
            tot_sum = tot_sum + SUMW'(r_s3_sum[k]);
            tot_cnt = tot_cnt + CNTW'(r_s3_cnt[k]);
        end
        thr_prod = (8 + CNTW)'(i_cfg.dark_threshold) * (8 + CNTW)'(r_s4_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= r_s1_valid && r_s1_eval && lbl_ok;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_r   <= r_s1_r - 11'(WINDOW - 1);
            r_s2_c   <= 11'(13'(r_s1_c) - 13'(WINDOW - 1));
            r_s2_lbl <= r_ldelay[1];
            r_s3_r   <= r_s2_r;
            r_s3_c   <= r_s2_c;
            r_s3_lbl <= r_s2_lbl;
            r_s3_sum <= row_sum;
            r_s3_cnt <= row_cnt;
            r_s4_r   <= r_s3_r;
            r_s4_c   <= r_s3_c;
            r_s4_lbl <= r_s3_lbl;
            r_s4_sum <= tot_sum;
            r_s4_cnt <= tot_cnt;
        end
    end

    assign o_push                = i_en && r_s4_valid;
    assign o_push_data.pixel_row = r_s4_r;
    assign o_push_data.pixel_col = r_s4_c;
    assign o_push_data.region_id = r_s4_lbl;
    assign o_push_data.dark_mark = (r_s4_cnt != '0)
                                 && ((8 + CNTW)'(r_s4_sum) < thr_prod);

endmodule

@@ design/dsrc_fifo.sv @@
// dsrc_fifo: short queue of classified pixels between front and back
// depends on dsrc_pkg

module dsrc_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  dsrc_pkg::t_queue_item i_push_data,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output dsrc_pkg::t_queue_item o_head
);

    dsrc_pkg::t_queue_item r_buf [dsrc_pkg::QUEUE_DEPTH];

    logic [dsrc_pkg::QPTR_W-1:0] r_wptr;
    logic [dsrc_pkg::QPTR_W-1:0] r_rptr;
    logic [dsrc_pkg::QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_push_data;
        end
    end

    assign o_full  = (r_count == dsrc_pkg::QCNT_W'(dsrc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_buf[r_rptr];

endmodule

@@ design/dsrc_back.sv @@
// dsrc_back: per-region size and dark counters and the result register
// depends on dsrc_pkg

module dsrc_back #(
    parameter int unsigned NUM_REGIONS = 256,
    parameter int unsigned CLR_W       = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clr_active,
    input  logic [CLR_W-1:0]      i_clr_idx,
    input  logic                  i_q_empty,
    input  dsrc_pkg::t_queue_item i_q_head,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output dsrc_pkg::t_out_item   o_out_data
);

    localparam int unsigned RW = $clog2(NUM_REGIONS);

    typedef struct packed {
        logic [dsrc_pkg::CNT_W-1:0] size;
        logic [dsrc_pkg::CNT_W-1:0] dark;
    } t_counts;

    t_counts mem [NUM_REGIONS];

    logic                  b_en;
    logic                  wr_en;
    logic                  r_b1_valid;
    dsrc_pkg::t_queue_item r_b1_item;
    t_counts               r_rd_q;
    logic                  r_fwd;
    t_counts               r_fwd_val;
    t_counts               cur;
    t_counts               upd;
    logic                  r_out_valid;
    dsrc_pkg::t_out_item   r_out_data;

    function automatic logic [dsrc_pkg::CNT_W-1:0] sat_inc(
        input logic [dsrc_pkg::CNT_W-1:0] v
    );
        return (v == dsrc_pkg::CNT_MAX) ? v : v + 1'b1;
    endfunction

    assign b_en  = !r_out_valid || !i_out_stall;
    assign o_pop = b_en && !i_q_empty;
    assign wr_en = b_en && r_b1_valid;

    always_comb begin
        cur      = r_fwd ? r_fwd_val : r_rd_q;
        upd.size = sat_inc(cur.size);
        upd.dark = r_b1_item.dark_mark ? sat_inc(cur.dark) : cur.dark;
    end

    always_ff @(posedge i_clk) begin
        if (i_clr_active) begin
            if (32'(i_clr_idx) < NUM_REGIONS) begin
                mem[i_clr_idx[RW-1:0]] <= '0;
            end
        end else if (wr_en) begin
            mem[r_b1_item.region_id[RW-1:0]] <= upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_rd_q    <= mem[i_q_head.region_id[RW-1:0]];
            r_fwd     <= r_b1_valid && (r_b1_item.region_id == i_q_head.region_id);
            r_fwd_val <= upd;
            r_b1_item <= i_q_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (b_en) begin
            r_b1_valid  <= o_pop;
            r_out_valid <= r_b1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_out_data.pixel_row          <= r_b1_item.pixel_row;
            r_out_data.pixel_col          <= r_b1_item.pixel_col;
            r_out_data.dark_mark          <= r_b1_item.dark_mark;
            r_out_data.region_id          <= r_b1_item.region_id;
            r_out_data.region_pixel_count <= upd.size;
            r_out_data.region_dark_count  <= upd.dark;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ design/dark_spot_region_counter_core.sv @@
// dark_spot_region_counter_core: top level of the dark spot region counter
// depends on dsrc_pkg, dsrc_front, dsrc_fifo, dsrc_back
//
// usage
// - input channel (i_in_valid / o_in_stall) takes one raster pixel item per
//   clock while o_in_stall is low: gray level and region label
// - output channel (o_out_valid / i_out_stall) gives one item for each pixel
//   whose window lies inside the evaluated area and whose label is a valid
//   region: position, dark mark and the region's updated counters
// - config (i_cfg_valid / o_cfg_ready) writes width, height and threshold;
//   ready is always high; the user writes only while idle, not enforced
// - a pixel is evaluated when the pixel WINDOW-1 rows and columns later
//   arrives; from that accept the item passes the first front stage, 3 more
//   front stages, the queue, the counter read and the result register
// - throughput is one item per clock when not stalled, set by the single
//   line store read and one counter read-modify-write per clock, forwarded
// - after reset a clearing pass over every index of the larger store zeroes
//   the line store and the counters; o_in_stall stays high meanwhile
// - when the receiver stalls, the result register holds, the queue fills
//   and then the front stalls the input side

module dark_spot_region_counter_core #(
    parameter int unsigned WINDOW      = 3,
    parameter int unsigned MAX_WIDTH   = 2048,
    parameter int unsigned NUM_REGIONS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dsrc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dsrc_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [11:0]         i_cfg_data
);

    // clearing pass covers the larger of the two stores
    localparam int unsigned CLR_LEN = (MAX_WIDTH > NUM_REGIONS) ? MAX_WIDTH : NUM_REGIONS;
    localparam int unsigned CLR_W   = $clog2(CLR_LEN);

    dsrc_pkg::t_cfg        r_cfg;
    logic                  r_clr_active;
    logic [CLR_W-1:0]      r_clr_idx;
    logic                  f_en;
    logic                  push;
    dsrc_pkg::t_queue_item push_data;
    logic                  q_full;
    logic                  q_empty;
    logic                  pop;
    dsrc_pkg::t_queue_item q_head;

    // config registers, unknown indexes ignored
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width    <= dsrc_pkg::RST_IMAGE_WIDTH;
            r_cfg.image_height   <= dsrc_pkg::RST_IMAGE_HEIGHT;
            r_cfg.dark_threshold <= dsrc_pkg::RST_DARK_THRESHOLD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dsrc_pkg::CFG_IMAGE_WIDTH:    r_cfg.image_width    <= i_cfg_data;
                dsrc_pkg::CFG_IMAGE_HEIGHT:   r_cfg.image_height   <= i_cfg_data;
                dsrc_pkg::CFG_DARK_THRESHOLD: r_cfg.dark_threshold <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_idx    <= '0;
        end else if (r_clr_active) begin
            if (r_clr_idx == CLR_W'(CLR_LEN - 1)) begin
                r_clr_active <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    // whole front advances together while the queue has room, after clearing
    assign f_en       = !r_clr_active && !q_full;
    assign o_in_stall = !f_en;

    dsrc_front #(
        .WINDOW      (WINDOW),
        .MAX_WIDTH   (MAX_WIDTH),
        .NUM_REGIONS (NUM_REGIONS),
        .CLR_W       (CLR_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (f_en),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .i_cfg        (r_cfg),
        .i_clr_active (r_clr_active),
        .i_clr_idx    (r_clr_idx),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    dsrc_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_full      (q_full),
        .o_empty     (q_empty),
        .o_head      (q_head)
    );

    dsrc_back #(
        .NUM_REGIONS (NUM_REGIONS),
        .CLR_W       (CLR_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clr_active (r_clr_active),
        .i_clr_idx    (r_clr_idx),
        .i_q_empty    (q_empty),
        .i_q_head     (q_head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule

@@ design/dsrc_checker.sv @@
// dsrc_checker: port-level assertions for the dark spot region counter
// depends on dsrc_pkg; bound to dark_spot_region_counter_core

module dsrc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input dsrc_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input dsrc_pkg::t_out_item o_out_data,
    input logic                i_cfg_valid,
    input logic                o_cfg_ready,
    input logic [1:0]          i_cfg_index,
    input logic [11:0]         i_cfg_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // background pixels never give a result
    a_region_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.region_id != 8'd0)
        else $error("result for background label");

    // dark count never passes region size
    a_dark_le_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.region_dark_count <= o_out_data.region_pixel_count)
        else $error("dark count above pixel count");

    // a dark pixel leaves a nonzero dark count
    a_dark_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.dark_mark |-> o_out_data.region_dark_count != '0)
        else $error("dark pixel not counted");

    // input is held off as reset is released, at the start of the clearing pass
    a_clear_stall: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> o_in_stall)
        else $error("input accepted during clearing");

endmodule

bind dark_spot_region_counter_core dsrc_checker u_dsrc_checker (.*);

@@ verif/dark_spot_region_counter_core_test.sv @@
// dark_spot_region_counter_core_test: self-checking bench for the dark spot region counter
// depends on dsrc_pkg and dark_spot_region_counter_core; a built-in predictor of the
// window sums and region counters is checked against every output item
`timescale 1ns / 100ps

module dark_spot_region_counter_core_test;

    localparam int WIN     = 3;
    localparam int MAXW    = 2048;
    localparam int NREG    = 256;
    localparam int LAT_GAP = 20;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    dsrc_pkg::t_in_item  i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    dsrc_pkg::t_out_item o_out_data;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index = '0;
    logic [11:0]         i_cfg_data = '0;

    dark_spot_region_counter_core i_dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [11:0] cfg_width = dsrc_pkg::RST_IMAGE_WIDTH;
    logic [11:0] cfg_height = dsrc_pkg::RST_IMAGE_HEIGHT;
    logic [7:0]  cfg_thr = dsrc_pkg::RST_DARK_THRESHOLD;
    logic [7:0]  gray_lines[2][MAXW];
    logic [7:0]  label_lines[2][MAXW];
    logic [dsrc_pkg::CNT_W-1:0] size_cnt[NREG];
    logic [dsrc_pkg::CNT_W-1:0] dark_cnt[NREG];
    logic [7:0]  win[WIN][WIN];
    logic [7:0]  label_dly[WIN];
    int          cur_row = 0;
    int          cur_col = 0;

    dsrc_pkg::t_in_item  pixel_queue[$];
    dsrc_pkg::t_out_item pending_results[$];
    int          errors = 0;
    int          pixels_sent = 0;
    int          results_seen = 0;
    int          dark_seen = 0;
    bit          idling = 1'b1;
    bit          hold_off = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;

    initial begin
        foreach (gray_lines[k, c]) begin
            gray_lines[k][c] = '0;
            label_lines[k][c] = '0;
        end
        foreach (size_cnt[r]) begin
            size_cnt[r] = '0;
            dark_cnt[r] = '0;
        end
        foreach (win[a, b]) win[a][b] = '0;
        foreach (label_dly[a]) label_dly[a] = '0;
    end

    function automatic logic [dsrc_pkg::CNT_W-1:0] sat_inc(logic [dsrc_pkg::CNT_W-1:0] v);
        return (v == dsrc_pkg::CNT_MAX) ? v : v + 1'b1;
    endfunction

    // advance the window by one pixel and queue the result it causes, if any
    function automatic void predict_pixel(dsrc_pkg::t_in_item px);
        int effw, effh, r, c, lbl, sum, cnt;
        dsrc_pkg::t_out_item res;
        effw = (cfg_width > MAXW) ? MAXW : cfg_width;
        effh = (cfg_height > dsrc_pkg::MAX_HEIGHT) ? dsrc_pkg::MAX_HEIGHT : cfg_height;
        r = cur_row;
        c = cur_col % MAXW;
        // shift window left, new column from the line stores and the new pixel
        for (int k = 0; k < WIN; k++) begin
            for (int m = 0; m < WIN - 1; m++) win[k][m] = win[k][m + 1];
        end
        win[0][WIN - 1] = gray_lines[0][c];
        win[1][WIN - 1] = gray_lines[1][c];
        win[2][WIN - 1] = px.gray_level;
        for (int m = 0; m < WIN - 1; m++) label_dly[m] = label_dly[m + 1];
        label_dly[WIN - 1] = label_lines[0][c];
        gray_lines[0][c] = gray_lines[1][c];
        label_lines[0][c] = label_lines[1][c];
        gray_lines[1][c] = px.gray_level;
        label_lines[1][c] = px.region_label;
        // pixel two rows up and two columns left is complete now
        if (r >= 2 * WIN - 1 && c >= 2 * WIN - 1 && c + 2 <= effw) begin
            lbl = label_dly[0];
            if (lbl != 0 && lbl < NREG) begin
                sum = 0;
                cnt = 0;
                foreach (win[a, b]) begin
                    sum += win[a][b];
                    if (win[a][b] != 0) cnt++;
                end
                res.dark_mark = (cnt > 0 && sum < cfg_thr * cnt);
                size_cnt[lbl] = sat_inc(size_cnt[lbl]);
                if (res.dark_mark) dark_cnt[lbl] = sat_inc(dark_cnt[lbl]);
                res.pixel_row = 11'(r - (WIN - 1));
                res.pixel_col = 11'(c - (WIN - 1));
                res.region_id = 8'(lbl);
                res.region_pixel_count = size_cnt[lbl];
                res.region_dark_count = dark_cnt[lbl];
                pending_results.push_back(res);
            end
        end
        c++;
        if (c >= effw) begin
            c = 0;
            r++;
            if (r >= effh) r = 0;
        end
        cur_col = c;
        cur_row = r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int rand_gap();
        int p;
        p = $urandom_range(99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // pixel driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_pixel(i_in_data);
                pixels_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pixel_queue.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pixel_queue.pop_front();
                    gap_left <= idling ? rand_gap() : 0;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        dsrc_pkg::t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    $error("output item with no result pending");
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("pixel_row", want.pixel_row, o_out_data.pixel_row);
                    check_field("pixel_col", want.pixel_col, o_out_data.pixel_col);
                    check_field("dark_mark", want.dark_mark, o_out_data.dark_mark);
                    check_field("region_id", want.region_id, o_out_data.region_id);
                    check_field("region_pixel_count", want.region_pixel_count,
                                o_out_data.region_pixel_count);
                    check_field("region_dark_count", want.region_dark_count,
                                o_out_data.region_dark_count);
                    if (o_out_data.dark_mark) dark_seen++;
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= hold_off;
                stall_left <= idling ? rand_gap() : 0;
            end
        end
    end

    // register write, only while idle
    task automatic write_reg(logic [1:0] idx, logic [11:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            dsrc_pkg::CFG_IMAGE_WIDTH:    cfg_width = val;
            dsrc_pkg::CFG_IMAGE_HEIGHT:   cfg_height = val;
            dsrc_pkg::CFG_DARK_THRESHOLD: cfg_thr = val[7:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(int w, int h, int thr);
        write_reg(dsrc_pkg::CFG_IMAGE_WIDTH, 12'(w));
        write_reg(dsrc_pkg::CFG_IMAGE_HEIGHT, 12'(h));
        write_reg(dsrc_pkg::CFG_DARK_THRESHOLD, 12'(thr));
    endtask

    // pixel content: zero_pct steers toward all-zero windows
    function automatic dsrc_pkg::t_in_item rand_pixel(int zero_pct);
        dsrc_pkg::t_in_item px;
        int p;
        p = $urandom_range(99);
        if (p < zero_pct)   px.gray_level = 8'd0;
        else if (p < 60)    px.gray_level = 8'($urandom_range(120));
        else                px.gray_level = 8'($urandom_range(255));
        p = $urandom_range(99);
        if (p < 10)         px.region_label = 8'd0;
        else if (p < 85)    px.region_label = 8'($urandom_range(6, 1));
        else                px.region_label = 8'($urandom_range(255, 1));
        return px;
    endfunction

    // wait until all pixels went in and every result came back
    task automatic drain();
        while (pixel_queue.size() > 0 || i_in_valid) @(posedge i_clk);
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (LAT_GAP) @(posedge i_clk);
    endtask

    task automatic run_frame(int n, int zero_pct);
        for (int k = 0; k < n; k++) pixel_queue.push_back(rand_pixel(zero_pct));
        drain();
    endtask

    initial begin
        dsrc_pkg::t_in_item px;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes on row 0 with reset settings
        for (int k = 0; k < 16; k++) begin
            px.gray_level = (k % 2) ? 8'hFF : 8'h00;
            px.region_label = (k % 3 == 0) ? 8'hFF : ((k % 3 == 1) ? 8'h00 : 8'h01);
            pixel_queue.push_back(px);
        end
        drain();

        // 8 by 8 frame, highest threshold, unused register index ignored
        set_frame(8, 8, 255);
        write_reg(2'd3, 12'hFFF);
        run_frame(300, 20);

        // height beyond the limit, threshold zero, no idling
        idling = 1'b0;
        set_frame(10, 4095, 0);
        run_frame(250, 10);
        idling = 1'b1;

        // zero width, then zero height: nothing gets evaluated
        set_frame(0, 8, 60);
        run_frame(25, 10);
        set_frame(8, 0, 60);
        run_frame(25, 10);

        // width beyond the limit
        set_frame(4095, 8, 128);
        run_frame(250, 10);

        // mostly zero gray so that all-zero windows occur
        set_frame(16, 16, 100);
        run_frame(350, 85);

        // long receiver hold-off while the sender keeps going
        set_frame(9, 9, 60);
        for (int k = 0; k < 750; k++) pixel_queue.push_back(rand_pixel(15));
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join_none
        drain();
        set_frame(2048, 2048, 0);

        $display("covered %0d pixels and %0d region results (%0d dark)",
                 pixels_sent, results_seen, dark_seen);
        $display("over frame sizes 0 to 4095, thresholds 0 to 255 and a long hold-off");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ dark_spot_region_counter_core.f @@
design/dsrc_pkg.sv
design/dsrc_front.sv
design/dsrc_fifo.sv
design/dsrc_back.sv
design/dark_spot_region_counter_core.sv
design/dsrc_checker.sv
verif/dark_spot_region_counter_core_test.sv
